// ===== rtl/core/hbi_pkg.sv =====
package hbi_pkg;

   localparam int unsigned SampleWidth  = 64;
   localparam int unsigned QuantumWidth = 32;
   localparam int unsigned CountWidth   = 11;
   localparam int unsigned CsrIdxWidth  = 2;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_AXIS_MINIMUM = 2'd0,
      CSR_QUANTUM_SIZE = 2'd1,
      CSR_BUCKET_COUNT = 2'd2,
      CSR_LOG_SCALE    = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic under;
   } ctl_type;

endpackage

// ===== rtl/core/hbi_div_cell.sv =====
module hbi_div_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                enable,
   input  hbi_pkg::ctl_type                    ctl_in,
   input  logic [hbi_pkg::QuantumWidth-1:0]    rem_in,
   input  logic [hbi_pkg::SampleWidth-1:0]     dq_in,
   input  logic [hbi_pkg::QuantumWidth-1:0]    divisor,
   output hbi_pkg::ctl_type                    ctl_out,
   output logic [hbi_pkg::QuantumWidth-1:0]    rem_out,
   output logic [hbi_pkg::SampleWidth-1:0]     dq_out
);
   import hbi_pkg::*;

   ctl_type                  ctl_ff;
   logic [QuantumWidth-1:0]  rem_ff, rem_in_w;
   logic [SampleWidth-1:0]   dq_ff, dq_in_w;
   logic [QuantumWidth:0]    shifted, diff;
   logic                     ge;

   always_comb begin
      shifted  = {rem_in, dq_in[SampleWidth-1]};
      ge       = shifted >= {1'b0, divisor};
      diff     = shifted - {1'b0, divisor};
      rem_in_w = ge ? diff[QuantumWidth-1:0] : shifted[QuantumWidth-1:0];
      dq_in_w  = {dq_in[SampleWidth-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (enable) begin
         ctl_ff <= ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff <= rem_in_w;
         dq_ff  <= dq_in_w;
      end
   end

   assign ctl_out = ctl_ff;
   assign rem_out = rem_ff;
   assign dq_out  = dq_ff;

endmodule

// ===== rtl/core/histogram_bucket_index_unit.sv =====
// Histogram bucket classifier: each signed 64-bit sample word yields one bucket word.
// The offset from axis_minimum runs through a chain of 64 restoring-division cells,
// one quotient bit per cell, followed by one bucket/clamp stage; a new sample is taken
// every cycle while the chain advances. The whole chain advances together; it holds
// only while the output word waits and is not taken.
// Configuration must be written while no sample is in flight.
module histogram_bucket_index_unit #(
   parameter int unsigned MAX_BUCKETS = 1024
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   input  logic [hbi_pkg::SampleWidth-1:0]        req_tdata,  // [63:0] sample
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   output logic [(((MAX_BUCKETS > 1 ? $clog2(MAX_BUCKETS) : 1) + 7) / 8) * 8 - 1:0]
                                                  rsp_tdata,  // bucket, zero filled
   input  logic                                   csr_we,
   input  logic [hbi_pkg::CsrIdxWidth-1:0]        csr_index,
   input  logic [hbi_pkg::SampleWidth-1:0]        csr_wdata
);
   import hbi_pkg::*;

   localparam int unsigned BW     = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int unsigned TW     = ((BW + 7) / 8) * 8;
   localparam int unsigned CW     = $clog2(MAX_BUCKETS + 1) + 1;
   localparam int unsigned Stages = SampleWidth;

   logic [SampleWidth-1:0]  minimum_ff;
   logic [QuantumWidth-1:0] quantum_ff;
   logic [CountWidth-1:0]   count_ff;
   logic                    log_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         minimum_ff <= '0;
         quantum_ff <= QuantumWidth'(1);
         count_ff   <= CountWidth'(1024);
         log_ff     <= 1'b0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_AXIS_MINIMUM: minimum_ff <= csr_wdata;
            CSR_QUANTUM_SIZE: quantum_ff <= csr_wdata[QuantumWidth-1:0];
            CSR_BUCKET_COUNT: count_ff   <= csr_wdata[CountWidth-1:0];
            CSR_LOG_SCALE:    log_ff     <= csr_wdata[0];
            default:          log_ff     <= log_ff;
         endcase
      end
   end

   logic [QuantumWidth-1:0] divisor;
   logic [CW-1:0]           cnt;
   logic [BW-1:0]           last;

   always_comb begin
      divisor = (quantum_ff == '0) ? QuantumWidth'(1) : quantum_ff;
      cnt     = (count_ff == '0) ? CW'(1) : CW'(count_ff);
      if (cnt > CW'(MAX_BUCKETS)) begin
         cnt = CW'(MAX_BUCKETS);
      end
      last = BW'(cnt - CW'(1));
   end

   logic             enable;
   logic             rsp_valid_ff;
   logic [BW-1:0]    bucket_ff, bucket_in;

   assign enable     = !rsp_valid_ff || rsp_tready;
   assign req_tready = enable;

   ctl_type                 ctl   [0:Stages];
   logic [QuantumWidth-1:0] rem   [0:Stages];
   logic [SampleWidth-1:0]  dq    [0:Stages];

   always_comb begin
      ctl[0].valid = req_tvalid;
      ctl[0].under = $signed(req_tdata) < $signed(minimum_ff);
      rem[0]       = '0;
      dq[0]        = req_tdata - minimum_ff;
   end

   for (genvar i = 0; i < Stages; i++) begin : g_cell
      hbi_div_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .enable  (enable),
         .ctl_in  (ctl[i]),
         .rem_in  (rem[i]),
         .dq_in   (dq[i]),
         .divisor (divisor),
         .ctl_out (ctl[i+1]),
         .rem_out (rem[i+1]),
         .dq_out  (dq[i+1])
      );
   end

   logic [SampleWidth-1:0] q;
   logic [6:0]             bitlen;
   logic [7:0]             want;

   always_comb begin
      q      = dq[Stages];
      bitlen = '0;
      for (int i = 0; i < SampleWidth; i++) begin
         if (q[i]) begin
            bitlen = 7'(i + 1);
         end
      end
      want = {1'b0, bitlen} + 8'd1;
      if (ctl[Stages].under) begin
         bucket_in = '0;
      end else if (log_ff) begin
         bucket_in = (32'(want) < 32'(last)) ? BW'(want) : last;
      end else begin
         bucket_in = (q >= SampleWidth'(last)) ? last : BW'(q + SampleWidth'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= ctl[Stages].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         bucket_ff <= bucket_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TW'(bucket_ff);

endmodule
